[rtl/rsa_pkg.sv]
// Request slot allocator package: field widths, request mode codes and
// configuration register indexes shared by the allocator modules.
// No dependencies.
package rsa_pkg;

	localparam int IDS_PER_SOCKET = 256;
	localparam int ID_W           = 8;
	localparam int WORD_W         = 32;
	localparam int WORD_OFF_W     = 5;
	localparam int HEAD_W         = 32;
	localparam int MOD_BITS       = 4;

	localparam int MODE_W         = 2;
	localparam int SOCKET_W       = 4;
	localparam int SLOT_W         = 12;
	localparam int SERVER_CNT_W   = 5;
	localparam int SLOT_CNT_W     = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIND    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REMAP_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;

	localparam logic [SERVER_CNT_W-1:0] SERVER_CNT_RST = 5'd16;
	localparam logic [SLOT_CNT_W-1:0]   SLOT_CNT_RST   = 13'd4096;

endpackage

[rtl/rsa_mod.sv]
// Iterative remainder unit: 32-bit dividend modulo a narrow divisor,
// several restoring steps per cycle. Depends on rsa_pkg.
module rsa_mod #(
	parameter int DIV_W = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rsa_pkg::HEAD_W-1:0] dividend,
	input  logic [DIV_W-1:0]           divisor,
	output logic                       done,
	output logic [DIV_W-1:0]           remainder
);

	localparam int CYCLES = rsa_pkg::HEAD_W / rsa_pkg::MOD_BITS;
	localparam int CNT_W  = $clog2(CYCLES);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [rsa_pkg::HEAD_W-1:0] num_q;
	logic [DIV_W-1:0]           rem_q;
	logic [DIV_W-1:0]           rem_nx;

	always_comb begin
		logic [DIV_W:0]   t;
		logic [DIV_W-1:0] r;
		r = rem_q;
		t = '0;
		for (int i = 0; i < rsa_pkg::MOD_BITS; i++) begin
			t = {r, num_q[rsa_pkg::HEAD_W-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[DIV_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << rsa_pkg::MOD_BITS;
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[rtl/rsa_bitmap.sv]
// Slot used-bit memory, one word of 32 slots per entry, with a clearing
// sweep after reset. Depends on rsa_pkg.
module rsa_bitmap #(
	parameter int WORDS   = 128,
	parameter int WADDR_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [WADDR_W-1:0]         rd_addr,
	output logic [rsa_pkg::WORD_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [WADDR_W-1:0]         wr_addr,
	input  logic [rsa_pkg::WORD_W-1:0] wr_data,
	output logic                       clearing
);

	logic [rsa_pkg::WORD_W-1:0] mem [WORDS];
	logic [rsa_pkg::WORD_W-1:0] rd_data_q;
	logic                       clearing_q;
	logic [WADDR_W-1:0]         clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + WADDR_W'(1);
			if (clr_q == WADDR_W'(WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

[rtl/request_slot_allocator_core.sv]
// Request slot allocator: round-robin free-slot allocation over a used-bit
// bitmap, with find and release. Depends on rsa_pkg, rsa_mod, rsa_bitmap.
//
// A request is taken when start is high and busy is low; mode picks
// allocate, find or release; the unused code returns a zero result. Each
// request gives one result, shown on slot_index, hit and overwrote for one
// cycle while done is high. The receiver cannot stall; the next request may
// be taken in the cycle that done is high.
// Steps, start to done:
//   find, release: one bitmap read, then a check; release writes the word back with the bit cleared.
//   allocate: the head is reduced modulo the socket or slot count (4
//   remainder bits a cycle), then each probe is a bitmap read and a check. A
//   probe is one socket in transparent mode, up to one 32-slot bitmap word in
//   remap mode. Probes at most: server count in transparent mode; in remap
//   mode, the words walked, up to slot count / 32 + 2.
// The bitmap read-modify-write loop sets the rate: one request at a time.
// After reset the bitmap is swept to zero, one word a cycle, over all
// MAX_SOCKETS * 8 words (128 by default); busy stays high meanwhile.
// Configuration writes are taken in any cycle, including the sweep.
module request_slot_allocator_core #(
	parameter int MAX_SOCKETS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rsa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rsa_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rsa_pkg::MODE_W-1:0]           mode,
	input  logic [rsa_pkg::SOCKET_W-1:0]         socket_index,
	input  logic [rsa_pkg::ID_W-1:0]             wanted_id,
	input  logic [rsa_pkg::SLOT_W-1:0]           release_index,
	output logic                                 done,
	output logic [rsa_pkg::SLOT_W-1:0]           slot_index,
	output logic                                 hit,
	output logic                                 overwrote
);

	localparam int SLOT_DEPTH = MAX_SOCKETS * rsa_pkg::IDS_PER_SOCKET;
	localparam int IDX_W      = $clog2(SLOT_DEPTH);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OFF_W      = rsa_pkg::WORD_OFF_W;
	localparam int WADDR_W    = IDX_W - OFF_W;
	localparam int WORDS      = SLOT_DEPTH / rsa_pkg::WORD_W;
	localparam int SOCK_W     = (IDX_W > rsa_pkg::ID_W) ? IDX_W - rsa_pkg::ID_W : 1;
	localparam int HW         = rsa_pkg::HEAD_W;
	localparam int WW         = rsa_pkg::WORD_W;

	typedef enum logic [1:0] {S_IDLE, S_MOD, S_RD, S_CHK} state_t;

	function automatic logic [IDX_W-1:0] sock_slot(input logic [SOCK_W-1:0] s,
		input logic [rsa_pkg::ID_W-1:0] id);
		logic [SOCK_W+rsa_pkg::ID_W-1:0] full;
		full = {s, id};
		return full[IDX_W-1:0];
	endfunction

	function automatic logic [rsa_pkg::SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[rsa_pkg::SLOT_W-1:0];
	endfunction

	state_t                          state_q;
	logic                            remap_q;
	logic [rsa_pkg::SERVER_CNT_W-1:0] srv_cnt_q;
	logic [rsa_pkg::SLOT_CNT_W-1:0]  slot_cnt_q;
	logic [HW-1:0]                   head_q;
	logic [rsa_pkg::MODE_W-1:0]      mode_q;
	logic [rsa_pkg::ID_W-1:0]        id_q;
	logic                            range_q;
	logic [rsa_pkg::SLOT_W-1:0]      where_q;
	logic [IDX_W-1:0]                pos_q;
	logic [IDX_W-1:0]                p0_q;
	logic [SOCK_W-1:0]               sock_q;
	logic [CNT_W-1:0]                rem_q;
	logic [HW-1:0]                   cur_q;
	logic [5:0]                      n_q;
	logic [WW-1:0]                   mask_q;
	logic                            done_q;
	logic [rsa_pkg::SLOT_W-1:0]      slot_q;
	logic                            hit_q;
	logic                            over_q;

	logic [CNT_W-1:0] eff_srv;
	logic [CNT_W-1:0] eff_slot;
	logic             accept;
	logic             clearing;
	logic [31:0]      find32;
	logic [31:0]      rel32;
	logic             mod_start;
	logic             mod_done;
	logic [CNT_W-1:0] mod_rem;

	logic [OFF_W-1:0] off;
	logic [5:0]       lim_a;
	logic [CNT_W-1:0] span_b;
	logic [5:0]       lim_b;
	logic [5:0]       lim_w;
	logic [5:0]       lim_r;
	logic [5:0]       n_rd;
	logic [WW-1:0]    mask_rd;

	logic [WW-1:0]    rd_data;
	logic [WW-1:0]    free;
	logic             found;
	logic [OFF_W-1:0] jsel;
	logic [OFF_W-1:0] jdiff;
	logic [IDX_W-1:0] hit_pos;
	logic [CNT_W-1:0] rem_nx;
	logic [HW-1:0]    cur_nx;
	logic [CNT_W-1:0] pos_sum;
	logic [CNT_W-1:0] sock_sum;
	logic [IDX_W-1:0] rpos_nx;
	logic [SOCK_W-1:0] sock_nx;
	logic             bit_old;
	logic             wr_en;
	logic [WW-1:0]    wr_data;

	assign accept    = start && !busy;
	assign busy      = clearing || (state_q != S_IDLE);
	assign mod_start = accept && (mode == rsa_pkg::MODE_ALLOC);
	assign find32    = {20'd0, socket_index, wanted_id};
	assign rel32     = {20'd0, release_index};

	always_comb begin
		if (srv_cnt_q == '0) begin
			eff_srv = CNT_W'(1);
		end else if (CNT_W'(srv_cnt_q) > CNT_W'(MAX_SOCKETS)) begin
			eff_srv = CNT_W'(MAX_SOCKETS);
		end else begin
			eff_srv = CNT_W'(srv_cnt_q);
		end
		if (slot_cnt_q == '0) begin
			eff_slot = CNT_W'(1);
		end else if (32'(slot_cnt_q) > 32'(SLOT_DEPTH)) begin
			eff_slot = CNT_W'(SLOT_DEPTH);
		end else begin
			eff_slot = CNT_W'(slot_cnt_q);
		end
	end

	// probe window for the word about to be read
	always_comb begin
		off    = pos_q[OFF_W-1:0];
		lim_a  = 6'd32 - {1'b0, off};
		span_b = eff_slot - CNT_W'(pos_q);
		lim_b  = (span_b > CNT_W'(32)) ? 6'd32 : span_b[5:0];
		lim_w  = (&cur_q[HW-1:OFF_W]) ? (6'd32 - {1'b0, cur_q[OFF_W-1:0]}) : 6'd32;
		lim_r  = (rem_q > CNT_W'(32)) ? 6'd32 : rem_q[5:0];
		n_rd   = lim_a;
		if (lim_b < n_rd) begin
			n_rd = lim_b;
		end
		if (lim_w < n_rd) begin
			n_rd = lim_w;
		end
		if (lim_r < n_rd) begin
			n_rd = lim_r;
		end
		for (int j = 0; j < WW; j++) begin
			mask_rd[j] = (6'(j) >= {1'b0, off}) && ((6'(j) - {1'b0, off}) < n_rd);
		end
		if (!(mode_q == rsa_pkg::MODE_ALLOC && remap_q)) begin
			n_rd    = 6'd1;
			mask_rd = WW'(1) << off;
		end
	end

	always_comb begin
		free  = ~rd_data & mask_q;
		found = 1'b0;
		jsel  = '0;
		for (int j = WW - 1; j >= 0; j--) begin
			if (free[j]) begin
				found = 1'b1;
				jsel  = OFF_W'(j);
			end
		end
		hit_pos  = {pos_q[IDX_W-1:OFF_W], jsel};
		jdiff    = jsel - pos_q[OFF_W-1:0];
		rem_nx   = rem_q - CNT_W'(n_q);
		cur_nx   = cur_q + HW'(n_q);
		pos_sum  = CNT_W'(pos_q) + CNT_W'(n_q);
		sock_sum = CNT_W'(sock_q) + CNT_W'(1);
		rpos_nx  = (cur_nx == '0 || pos_sum == eff_slot) ? '0 : pos_sum[IDX_W-1:0];
		sock_nx  = (sock_sum == eff_srv) ? '0 : sock_sum[SOCK_W-1:0];
		bit_old  = rd_data[pos_q[OFF_W-1:0]];
		wr_en    = 1'b0;
		wr_data  = rd_data;
		if (state_q == S_CHK) begin
			case (mode_q)
				rsa_pkg::MODE_ALLOC: begin
					if (found) begin
						wr_en   = 1'b1;
						wr_data = rd_data | (WW'(1) << jsel);
					end
				end
				rsa_pkg::MODE_RELEASE: begin
					if (range_q) begin
						wr_en   = 1'b1;
						wr_data = rd_data & ~(WW'(1) << pos_q[OFF_W-1:0]);
					end
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remap_q    <= 1'b0;
			srv_cnt_q  <= rsa_pkg::SERVER_CNT_RST;
			slot_cnt_q <= rsa_pkg::SLOT_CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsa_pkg::REG_REMAP_MODE:   remap_q    <= cfg_wdata[0];
				rsa_pkg::REG_SERVER_COUNT: srv_cnt_q  <= cfg_wdata[rsa_pkg::SERVER_CNT_W-1:0];
				rsa_pkg::REG_SLOT_COUNT:   slot_cnt_q <= cfg_wdata[rsa_pkg::SLOT_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			done_q  <= 1'b0;
			slot_q  <= '0;
			hit_q   <= 1'b0;
			over_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= mode;
						id_q   <= wanted_id;
						unique case (mode)
							rsa_pkg::MODE_ALLOC: begin
								state_q <= S_MOD;
							end
							rsa_pkg::MODE_FIND: begin
								where_q <= find32[rsa_pkg::SLOT_W-1:0];
								pos_q   <= find32[IDX_W-1:0];
								range_q <= find32 < 32'(eff_slot);
								state_q <= S_RD;
							end
							rsa_pkg::MODE_RELEASE: begin
								where_q <= release_index;
								pos_q   <= rel32[IDX_W-1:0];
								range_q <= rel32 < 32'(SLOT_DEPTH);
								state_q <= S_RD;
							end
							default: begin
								done_q <= 1'b1;
								slot_q <= '0;
								hit_q  <= 1'b0;
								over_q <= 1'b0;
							end
						endcase
					end
				end
				S_MOD: begin
					if (mod_done) begin
						if (remap_q) begin
							pos_q <= mod_rem[IDX_W-1:0];
							p0_q  <= mod_rem[IDX_W-1:0];
							cur_q <= head_q;
							rem_q <= eff_slot;
						end else begin
							sock_q <= mod_rem[SOCK_W-1:0];
							pos_q  <= sock_slot(mod_rem[SOCK_W-1:0], id_q);
							p0_q   <= sock_slot(mod_rem[SOCK_W-1:0], id_q);
							rem_q  <= eff_srv;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					n_q     <= n_rd;
					mask_q  <= mask_rd;
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= S_IDLE;
					if (mode_q == rsa_pkg::MODE_ALLOC) begin
						if (found) begin
							done_q <= 1'b1;
							slot_q <= slot_out(hit_pos);
							hit_q  <= 1'b1;
							over_q <= 1'b0;
							head_q <= remap_q ? (cur_q + HW'(jdiff) + HW'(1)) : (head_q + HW'(1));
						end else if (rem_nx == '0) begin
							done_q <= 1'b1;
							slot_q <= slot_out(p0_q);
							hit_q  <= 1'b0;
							over_q <= 1'b1;
							head_q <= head_q + HW'(1);
						end else begin
							rem_q   <= rem_nx;
							state_q <= S_RD;
							if (remap_q) begin
								cur_q <= cur_nx;
								pos_q <= rpos_nx;
							end else begin
								sock_q <= sock_nx;
								pos_q  <= sock_slot(sock_nx, id_q);
							end
						end
					end else begin
						done_q <= 1'b1;
						slot_q <= where_q;
						hit_q  <= range_q && bit_old;
						over_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	rsa_mod #(
		.DIV_W(CNT_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (head_q),
		.divisor  (remap_q ? eff_slot : eff_srv),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	rsa_bitmap #(
		.WORDS  (WORDS),
		.WADDR_W(WADDR_W)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == S_RD),
		.rd_addr (pos_q[IDX_W-1:OFF_W]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (pos_q[IDX_W-1:OFF_W]),
		.wr_data (wr_data),
		.clearing(clearing)
	);

	assign done       = done_q;
	assign slot_index = slot_q;
	assign hit        = hit_q;
	assign overwrote  = over_q;

	a_hit_over_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && overwrote))
		else $error("hit and overwrote both set");

	a_over_alloc_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overwrote) |-> (mode_q == rsa_pkg::MODE_ALLOC))
		else $error("overwrote on a non-allocate request");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !wr_en)
		else $error("bitmap write during clearing sweep");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE) || done)
		else $error("request taken without progress");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD))
		else $error("remainder ready outside wait state");

endmodule

[dv/request_slot_allocator_core_test.sv]
// Self-checking testbench for request_slot_allocator_core: directed and random allocate,
// find, release and unused-mode requests over several register settings, checked against
// a predictor. Depends on rsa_pkg and the allocator RTL.
module request_slot_allocator_core_test;

	localparam int MAX_SOCKETS = 16;
	localparam int SLOT_DEPTH  = MAX_SOCKETS * rsa_pkg::IDS_PER_SOCKET;
	localparam logic [rsa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_REQUESTS = 200;

	typedef struct packed {
		logic [rsa_pkg::MODE_W-1:0]   mode;
		logic [rsa_pkg::SOCKET_W-1:0] sock;
		logic [rsa_pkg::ID_W-1:0]     id;
		logic [rsa_pkg::SLOT_W-1:0]   rel;
	} slot_req_t;

	typedef struct packed {
		logic [rsa_pkg::SLOT_W-1:0] slot;
		logic                       hit;
		logic                       over;
	} slot_rsp_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [rsa_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [rsa_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                             start = 1'b0;
	logic                             busy;
	logic [rsa_pkg::MODE_W-1:0]       mode = '0;
	logic [rsa_pkg::SOCKET_W-1:0]     socket_index = '0;
	logic [rsa_pkg::ID_W-1:0]         wanted_id = '0;
	logic [rsa_pkg::SLOT_W-1:0]       release_index = '0;
	logic                             done;
	logic [rsa_pkg::SLOT_W-1:0]       slot_index;
	logic                             hit;
	logic                             overwrote;

	slot_req_t   pending_requests[$];
	slot_rsp_t   expected_slots[$];
	slot_req_t   next_req;
	slot_rsp_t   want_rsp;

	bit          slot_used [SLOT_DEPTH];
	int unsigned rotate_ptr = 0;
	logic        cfg_remap = 1'b0;
	logic [rsa_pkg::SERVER_CNT_W-1:0] cfg_servers = rsa_pkg::SERVER_CNT_RST;
	logic [rsa_pkg::SLOT_CNT_W-1:0]   cfg_slots = rsa_pkg::SLOT_CNT_RST;

	int unsigned idle_pct = 30;
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned n_alloc = 0;
	int unsigned n_over = 0;
	int unsigned n_find = 0;
	int unsigned n_release = 0;
	int unsigned n_unused = 0;
	int unsigned n_settings = 0;

	request_slot_allocator_core #(
		.MAX_SOCKETS(MAX_SOCKETS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.mode(mode),
		.socket_index(socket_index),
		.wanted_id(wanted_id),
		.release_index(release_index),
		.done(done),
		.slot_index(slot_index),
		.hit(hit),
		.overwrote(overwrote)
	);

	always #1 clk = ~clk;

	function automatic int unsigned servers_in_use();
		if (cfg_servers == 0)
			return 1;
		if (cfg_servers > MAX_SOCKETS)
			return MAX_SOCKETS;
		return 32'(cfg_servers);
	endfunction

	function automatic int unsigned slots_in_use();
		if (cfg_slots == 0)
			return 1;
		if (cfg_slots > SLOT_DEPTH)
			return SLOT_DEPTH;
		return 32'(cfg_slots);
	endfunction

	function automatic slot_rsp_t predict_slot_result(slot_req_t r);
		slot_rsp_t   res;
		int unsigned srv;
		int unsigned ring;
		int unsigned first;
		int unsigned pos;
		int unsigned k;
		int unsigned flat;
		bit          found;
		res = '0;
		found = 1'b0;
		pos = 0;
		srv = servers_in_use();
		ring = slots_in_use();
		case (r.mode)
			rsa_pkg::MODE_ALLOC: begin
				n_alloc++;
				if (!cfg_remap) begin
					first = rotate_ptr % srv;
					for (k = 0; k < srv && !found; k++) begin
						pos = ((first + k) % srv) * rsa_pkg::IDS_PER_SOCKET + r.id;
						if (!slot_used[pos]) begin
							found = 1'b1;
							rotate_ptr += 1;
						end
					end
					if (!found) begin
						pos = first * rsa_pkg::IDS_PER_SOCKET + r.id;
						rotate_ptr += 1;
					end
				end else begin
					for (k = 0; k < ring && !found; k++) begin
						flat = rotate_ptr + k;
						pos = flat % ring;
						if (!slot_used[pos]) begin
							found = 1'b1;
							rotate_ptr += k + 1;
						end
					end
					if (!found) begin
						pos = rotate_ptr % ring;
						rotate_ptr += 1;
					end
				end
				slot_used[pos] = 1'b1;
				res.slot = pos[rsa_pkg::SLOT_W-1:0];
				res.hit = found;
				res.over = !found;
				if (!found)
					n_over++;
			end
			rsa_pkg::MODE_FIND: begin
				n_find++;
				flat = r.sock * rsa_pkg::IDS_PER_SOCKET + r.id;
				res.slot = flat[rsa_pkg::SLOT_W-1:0];
				res.hit = (flat < ring) && slot_used[flat];
			end
			rsa_pkg::MODE_RELEASE: begin
				n_release++;
				res.slot = r.rel;
				res.hit = slot_used[r.rel];
				slot_used[r.rel] = 1'b0;
			end
			default: begin
				n_unused++;
			end
		endcase
		return res;
	endfunction

	// driver: hold a request while busy, otherwise take the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_slots.push_back(predict_slot_result({mode, socket_index, wanted_id,
					release_index}));
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_req = pending_requests.pop_front();
					start <= 1'b1;
					mode <= next_req.mode;
					socket_index <= next_req.sock;
					wanted_id <= next_req.id;
					release_index <= next_req.rel;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_we) begin
			case (cfg_index)
				rsa_pkg::REG_REMAP_MODE:   cfg_remap <= cfg_wdata[0];
				rsa_pkg::REG_SERVER_COUNT: cfg_servers <= cfg_wdata[rsa_pkg::SERVER_CNT_W-1:0];
				rsa_pkg::REG_SLOT_COUNT:   cfg_slots <= cfg_wdata[rsa_pkg::SLOT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_slots.size() == 0) begin
				errors++;
				$display("%0t: unexpected result slot_index %0d hit %0b overwrote %0b", $time,
					slot_index, hit, overwrote);
			end else begin
				want_rsp = expected_slots.pop_front();
				checked++;
				if (slot_index !== want_rsp.slot) begin
					errors++;
					$display("%0t: slot_index expected %0d actual %0d", $time, want_rsp.slot,
						slot_index);
				end
				if (hit !== want_rsp.hit) begin
					errors++;
					$display("%0t: hit expected %0b actual %0b", $time, want_rsp.hit, hit);
				end
				if (overwrote !== want_rsp.over) begin
					errors++;
					$display("%0t: overwrote expected %0b actual %0b", $time, want_rsp.over,
						overwrote);
				end
			end
		end
	end

	task automatic write_reg(logic [rsa_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[rsa_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int unsigned remap, int unsigned servers, int unsigned slots);
		write_reg(rsa_pkg::REG_REMAP_MODE, remap);
		write_reg(rsa_pkg::REG_SERVER_COUNT, servers);
		write_reg(rsa_pkg::REG_SLOT_COUNT, slots);
		@(posedge clk);
		n_settings++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() != 0 || start || expected_slots.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_req(logic [rsa_pkg::MODE_W-1:0] m, int unsigned sock, int unsigned id,
		int unsigned rel);
		slot_req_t r;
		r.mode = m;
		r.sock = sock[rsa_pkg::SOCKET_W-1:0];
		r.id = id[rsa_pkg::ID_W-1:0];
		r.rel = rel[rsa_pkg::SLOT_W-1:0];
		pending_requests.push_back(r);
	endtask

	task automatic queue_random_requests(int unsigned n);
		slot_req_t   r;
		int unsigned span;
		int unsigned pick;
		int unsigned flat;
		int unsigned i;
		span = cfg_remap ? slots_in_use() : servers_in_use() * rsa_pkg::IDS_PER_SOCKET;
		for (i = 0; i < n; i++) begin
			r.mode = 2'($urandom_range(3));
			r.sock = 4'($urandom_range(15));
			r.id = 8'($urandom_range(255));
			r.rel = 12'($urandom_range(SLOT_DEPTH - 1));
			pick = $urandom_range(99);
			if (pick < 45) begin
				r.mode = rsa_pkg::MODE_ALLOC;
				if ($urandom_range(1))
					r.id = 8'($urandom_range(7));
			end else if (pick < 70) begin
				r.mode = rsa_pkg::MODE_FIND;
				if ($urandom_range(9) < 8) begin
					flat = $urandom_range(span - 1);
					r.sock = flat[rsa_pkg::SOCKET_W+rsa_pkg::ID_W-1:rsa_pkg::ID_W];
					r.id = flat[rsa_pkg::ID_W-1:0];
				end
			end else if (pick < 95) begin
				r.mode = rsa_pkg::MODE_RELEASE;
				if ($urandom_range(9) < 8)
					r.rel = 12'($urandom_range(span - 1));
			end else begin
				r.mode = MODE_UNUSED;
			end
			pending_requests.push_back(r);
		end
	endtask

	initial begin
		int unsigned p;
		int unsigned servers;
		int unsigned slots;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		set_config(0, rsa_pkg::SERVER_CNT_RST, rsa_pkg::SLOT_CNT_RST);

		push_req(rsa_pkg::MODE_FIND, 0, 0, 0);
		push_req(rsa_pkg::MODE_ALLOC, 3, 0, 4095);
		push_req(rsa_pkg::MODE_ALLOC, 0, 0, 0);
		push_req(rsa_pkg::MODE_FIND, 0, 0, 0);
		push_req(rsa_pkg::MODE_FIND, 15, 255, 0);
		push_req(rsa_pkg::MODE_RELEASE, 0, 0, 0);
		push_req(rsa_pkg::MODE_RELEASE, 15, 255, 4095);
		push_req(MODE_UNUSED, 15, 255, 4095);
		push_req(rsa_pkg::MODE_ALLOC, 0, 255, 0);
		wait_idle();
		set_config(0, 1, 4096);
		push_req(rsa_pkg::MODE_ALLOC, 0, 5, 0);
		push_req(rsa_pkg::MODE_ALLOC, 0, 5, 0);
		wait_idle();
		set_config(0, 0, 4096);
		push_req(rsa_pkg::MODE_ALLOC, 0, 5, 0);
		wait_idle();
		set_config(0, 31, 4096);
		push_req(rsa_pkg::MODE_ALLOC, 0, 5, 0);
		wait_idle();
		set_config(1, 16, 4);
		repeat (5) push_req(rsa_pkg::MODE_ALLOC, 0, 0, 0);
		push_req(rsa_pkg::MODE_FIND, 0, 10, 0);
		push_req(rsa_pkg::MODE_RELEASE, 0, 0, 2);
		push_req(rsa_pkg::MODE_ALLOC, 0, 0, 0);
		wait_idle();
		set_config(1, 16, 0);
		push_req(rsa_pkg::MODE_ALLOC, 0, 0, 0);
		push_req(rsa_pkg::MODE_ALLOC, 0, 0, 0);
		wait_idle();
		set_config(1, 16, 8191);
		push_req(rsa_pkg::MODE_ALLOC, 0, 0, 0);
		push_req(rsa_pkg::MODE_FIND, 15, 255, 0);
		wait_idle();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(6))
				0: servers = 0;
				1: servers = 1;
				2: servers = 16;
				3: servers = 31;
				4: servers = $urandom_range(17, 31);
				default: servers = $urandom_range(1, 16);
			endcase
			case ($urandom_range(7))
				0: slots = 0;
				1: slots = 1;
				2: slots = 4096;
				3: slots = 8191;
				4: slots = $urandom_range(4097, 8191);
				5: slots = $urandom_range(1, 512);
				6: slots = (servers == 0 ? 1 : servers > 16 ? 16 : servers) *
					rsa_pkg::IDS_PER_SOCKET;
				default: slots = $urandom_range(2, 64);
			endcase
			set_config(p % 2, servers, slots);
			idle_pct = (p == 3) ? 0 : 30;
			queue_random_requests(PHASE_REQUESTS / 2);
			// pause until every expected result is back
			wait_idle();
			queue_random_requests(PHASE_REQUESTS / 2);
			wait_idle();
		end

		repeat (300) @(posedge clk);
		$display("Checked %0d results over %0d register settings: %0d allocations", checked,
			n_settings, n_alloc);
		$display("(%0d overwrites), %0d finds, %0d releases, %0d unused-mode requests",
			n_over, n_find, n_release, n_unused);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[request_slot_allocator_core.f]
rtl/rsa_pkg.sv
rtl/rsa_mod.sv
rtl/rsa_bitmap.sv
rtl/request_slot_allocator_core.sv
dv/request_slot_allocator_core_test.sv
